>>> rtl/imu_window_stillness_detector_core_assert.svh
// Assertion macros for the IMU window stillness detector core.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef IMU_WINDOW_STILLNESS_DETECTOR_CORE_ASSERT_SVH
`define IMU_WINDOW_STILLNESS_DETECTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define IWSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iwsd_pkg.sv
// Shared types and constants for the IMU window stillness detector.
// No dependencies; imported by every module of the block.
package iwsd_pkg;

  localparam int MAX_WINDOW_SAMPLES = 4096;
  localparam int FIFO_DEPTH         = 128;

  localparam int CNT_W  = 13;
  localparam int SUM_W  = 29;
  localparam int SQS_W  = 44;
  localparam int TIME_W = 48;
  localparam int PER_W  = 24;
  localparam int RATE_W = 20;
  localparam int MG_W   = 16;
  localparam int AX_W   = 16;

  // Serial divider geometry
  localparam int DVD_W  = 56;
  localparam int DVS_W  = 48;
  localparam int QCNT_W = 6;

  localparam logic [6:0]        POS_MAX    = 7'((FIFO_DEPTH > 128) ? 127 : FIFO_DEPTH - 1);
  localparam logic [23:0]       RATE_SCALE = 24'd10000000;
  localparam logic [15:0]       MG_SCALE   = 16'd1000;
  localparam logic [15:0]       EMA_OLD    = 16'd9;
  localparam logic [7:0]        EMA_DIV    = 8'd10;
  localparam logic [7:0]        EMA_ROUND  = 8'd5;
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;
  localparam logic [MG_W-1:0]   MG_MAX     = '1;
  localparam logic [PER_W-1:0]  PER_MAX    = '1;

  // Register reset values
  localparam logic [23:0] WINDOW_US_RST = 24'd1000000;
  localparam logic [15:0] ACC_STD_RST   = 16'd17;
  localparam logic [15:0] GYRO_MEAN_RST = 16'd66;
  localparam logic [15:0] CPG_RST       = 16'd8192;
  localparam logic [23:0] PERIOD_RST    = 24'd71111;
  localparam logic [19:0] MIN_RATE_RST  = 20'd500;

  typedef enum logic [2:0] {
    REG_WINDOW_US = 3'd0,
    REG_ACC_STD   = 3'd1,
    REG_GYRO_MEAN = 3'd2,
    REG_CPG       = 3'd3,
    REG_NOMINAL   = 3'd4,
    REG_MIN_RATE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] window_us;
    logic [15:0] still_acc_std;
    logic [15:0] still_gyro_mean;
    logic [15:0] accel_counts_per_g;
    logic [19:0] min_rate_x10;
  } cfg_t;

  typedef enum logic [5:0] {
    UOP_NOP, UOP_LOAD, UOP_TS_MUL, UOP_TS_SUB, UOP_SQ, UOP_SQ_ADD, UOP_RT_INIT,
    UOP_RT_STEP, UOP_ACC_A, UOP_ACC_A2, UOP_ACC_G, UOP_CHK, UOP_NRATE, UOP_RATE_SAT,
    UOP_RATE_START, UOP_RATE_RES, UOP_MEAS_START, UOP_P9, UOP_NP_START, UOP_PER,
    UOP_MG1, UOP_MG2, UOP_MG_START, UOP_MG_RES, UOP_MG_SAT, UOP_L1, UOP_L2, UOP_L3,
    UOP_L4, UOP_R1, UOP_R2, UOP_R3, UOP_R4, UOP_OUT
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic close;
    logic el_zero;
    logic upd;
    logic cpg_zero;
    logic div_busy;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
  endfunction

endpackage

>>> rtl/iwsd_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on iwsd_pkg for its widths.
module iwsd_div import iwsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W:0]    rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= QCNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[DVS_W-1:0];

endmodule

>>> rtl/iwsd_dp.sv
// Datapath: item latch, window sums, shared multiplier, square root steps,
// output register. Depends on iwsd_pkg and iwsd_div.
module iwsd_dp import iwsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  cfg_t             cfg,
  input  logic             per_load,
  input  logic [PER_W-1:0] per_load_val,
  input  logic [151:0]     in_tdata,
  input  logic             out_tready,
  output sts_t             sts,
  output logic             out_tvalid,
  output logic [87:0]      out_tdata,
  output logic             out_tuser
);

  // Window state
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  an_sum_r;
  logic [SQS_W-1:0]  sq_sum_r;
  logic [SUM_W-1:0]  gn_sum_r;
  logic [TIME_W-1:0] wstart_r;
  logic [PER_W-1:0]  period_r;

  // Latched item
  logic [TIME_W-1:0] it_t_r;
  logic [6:0]        it_pos_r;
  logic [AX_W-1:0]   it_ax_r [6];

  // Work registers
  logic [63:0]       p_r;
  logic [31:0]       ss_r;
  logic [31:0]       rt_x_r;
  logic [17:0]       rt_rem_r;
  logic [15:0]       rt_root_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [DVD_W-1:0]  meas_r;
  logic [63:0]       num_r;
  logic [63:0]       lhs_r;
  logic              still_a_r;

  // Pending result and output register
  logic [TIME_W-1:0] res_ts_r;
  logic              res_done_r;
  logic [RATE_W-1:0] res_rate_r;
  logic [MG_W-1:0]   res_mg_r;
  logic              res_still_r;
  logic              out_valid_r;
  logic [TIME_W-1:0] out_ts_r;
  logic              out_done_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [MG_W-1:0]   out_mg_r;
  logic              out_still_r;

  logic [47:0]       mul_a;
  logic [15:0]       mul_b;
  logic              mul_on;
  logic [63:0]       mul_prod;
  logic [6:0]        pos_c;
  logic [15:0]       mag_c;
  logic [19:0]       rt_rem2;
  logic [19:0]       rt_trial;
  logic [TIME_W-1:0] el_c;
  logic [63:0]       sq_c;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_busy;
  logic [DVD_W-1:0]  div_q;
  logic [DVS_W-1:0]  div_r;

  assign pos_c = (it_pos_r > POS_MAX) ? POS_MAX : it_pos_r;
  assign mag_c = mag16(it_ax_r[cmd.idx]);
  assign el_c  = it_t_r - wstart_r;
  assign sq_c  = num_r + {p_r[47:0], 16'd0};

  // Square root step: bring down two bits, try root*4+1
  assign rt_rem2  = {rt_rem_r, rt_x_r[31:30]};
  assign rt_trial = {2'b00, rt_root_r, 2'b01};

  // Select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_on = 1'b1;
    case (cmd.uop)
      UOP_TS_MUL:    begin mul_a = 48'(period_r);           mul_b = {9'd0, pos_c}; end
      UOP_SQ:        begin mul_a = 48'(mag_c);              mul_b = mag_c; end
      UOP_ACC_A:     begin mul_a = 48'(rt_root_r);          mul_b = rt_root_r; end
      UOP_NRATE:     begin mul_a = 48'(RATE_SCALE);         mul_b = 16'(cnt_r); end
      UOP_MG1:       begin mul_a = 48'(an_sum_r);           mul_b = MG_SCALE; end
      UOP_MG2:       begin mul_a = 48'(cnt_r);              mul_b = cfg.accel_counts_per_g; end
      UOP_L1:        begin mul_a = 48'(sq_sum_r);           mul_b = 16'(cnt_r); end
      UOP_L2:        begin mul_a = 48'(an_sum_r);           mul_b = an_sum_r[15:0]; end
      UOP_L3:        begin mul_a = 48'(an_sum_r);           mul_b = 16'(an_sum_r[28:16]); end
      UOP_L4:        begin mul_a = 48'(cfg.still_acc_std);  mul_b = cfg.still_acc_std; end
      UOP_R1, UOP_R2: begin mul_a = p_r[47:0];              mul_b = 16'(cnt_r); end
      UOP_R3:        begin mul_a = 48'(cfg.still_gyro_mean); mul_b = 16'(cnt_r); end
      UOP_P9:        begin mul_a = 48'(period_r);           mul_b = EMA_OLD; end
      default:       mul_on = 1'b0;
    endcase
  end

  assign mul_prod = 64'(mul_a) * 64'(mul_b);

  // Select divider operands
  always_comb begin
    div_start = 1'b1;
    div_dvd   = p_r[DVD_W-1:0];
    div_dvs   = elapsed_r;
    case (cmd.uop)
      UOP_RATE_START: ;
      UOP_MEAS_START: begin
        div_dvd = DVD_W'({elapsed_r, 4'd0});
        div_dvs = DVS_W'(cnt_r);
      end
      UOP_NP_START: begin
        div_dvd = p_r[DVD_W-1:0] + meas_r + DVD_W'(EMA_ROUND);
        div_dvs = DVS_W'(EMA_DIV);
      end
      UOP_MG_START: begin
        div_dvd = num_r[DVD_W-1:0];
        div_dvs = p_r[DVS_W-1:0];
      end
      default: div_start = 1'b0;
    endcase
  end

  iwsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q),
    .remainder(div_r)
  );

  // Window state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      an_sum_r    <= '0;
      sq_sum_r    <= '0;
      gn_sum_r    <= '0;
      wstart_r    <= '0;
      period_r    <= PERIOD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (per_load) begin
        period_r <= per_load_val;
      end
      case (cmd.uop)
        UOP_ACC_A:  an_sum_r <= an_sum_r + SUM_W'(rt_root_r);
        UOP_ACC_A2: sq_sum_r <= sq_sum_r + SQS_W'(p_r[31:0]);
        UOP_ACC_G: begin
          gn_sum_r <= gn_sum_r + SUM_W'(rt_root_r);
          cnt_r    <= cnt_r + 1'b1;
        end
        UOP_PER: period_r <= (div_q > DVD_W'(PER_MAX)) ? PER_MAX : div_q[PER_W-1:0];
        UOP_R4: begin
          cnt_r    <= '0;
          an_sum_r <= '0;
          sq_sum_r <= '0;
          gn_sum_r <= '0;
          wstart_r <= it_t_r;
        end
        UOP_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Work and result registers
  always_ff @(posedge clk) begin
    if (mul_on) begin
      p_r <= mul_prod;
    end
    case (cmd.uop)
      UOP_LOAD: begin
        it_t_r   <= in_tdata[47:0];
        it_pos_r <= in_tdata[54:48];
        for (int i = 0; i < 6; i++) begin
          it_ax_r[i] <= in_tdata[55 + 16*i +: 16];
        end
        res_ts_r    <= '0;
        res_done_r  <= 1'b0;
        res_rate_r  <= '0;
        res_mg_r    <= '0;
        res_still_r <= 1'b0;
      end
      UOP_TS_SUB: begin
        res_ts_r <= it_t_r - p_r[51:4];
        ss_r     <= '0;
        p_r      <= '0;
      end
      UOP_SQ, UOP_SQ_ADD: ss_r <= ss_r + p_r[31:0];
      UOP_RT_INIT: begin
        rt_x_r    <= ss_r;
        rt_rem_r  <= '0;
        rt_root_r <= '0;
      end
      UOP_RT_STEP: begin
        rt_x_r <= {rt_x_r[29:0], 2'b00};
        if (rt_rem2 >= rt_trial) begin
          rt_rem_r  <= 18'(rt_rem2 - rt_trial);
          rt_root_r <= {rt_root_r[14:0], 1'b1};
        end else begin
          rt_rem_r  <= rt_rem2[17:0];
          rt_root_r <= {rt_root_r[14:0], 1'b0};
        end
      end
      UOP_ACC_A2: begin
        ss_r <= '0;
        p_r  <= '0;
      end
      UOP_CHK:      elapsed_r  <= el_c;
      UOP_RATE_SAT: res_rate_r <= RATE_MAX;
      UOP_RATE_RES: res_rate_r <= (div_q > DVD_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
      UOP_P9:       meas_r     <= div_q;
      UOP_MG2:      num_r      <= p_r;
      UOP_MG_RES:   res_mg_r   <= (div_q > DVD_W'(MG_MAX)) ? MG_MAX : div_q[MG_W-1:0];
      UOP_MG_SAT:   res_mg_r   <= MG_MAX;
      UOP_L2:       lhs_r      <= p_r;
      UOP_L3:       num_r      <= p_r;
      UOP_L4:       lhs_r      <= (lhs_r > sq_c) ? (lhs_r - sq_c) : '0;
      UOP_R3:       still_a_r  <= lhs_r < p_r;
      UOP_R4: begin
        res_still_r <= still_a_r && (64'(gn_sum_r) < p_r);
        res_done_r  <= 1'b1;
      end
      UOP_OUT: begin
        out_ts_r    <= res_ts_r;
        out_done_r  <= res_done_r;
        out_rate_r  <= res_rate_r;
        out_mg_r    <= res_mg_r;
        out_still_r <= res_still_r;
      end
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    sts.full     = cnt_r >= CNT_W'(MAX_WINDOW_SAMPLES);
    sts.close    = (it_t_r >= wstart_r) && (el_c >= TIME_W'(cfg.window_us)) && (cnt_r != '0);
    sts.el_zero  = elapsed_r == '0;
    sts.upd      = (div_q > DVD_W'(cfg.min_rate_x10)) ||
                   ((div_q == DVD_W'(cfg.min_rate_x10)) && (div_r != '0));
    sts.cpg_zero = cfg.accel_counts_per_g == '0;
    sts.div_busy = div_busy;
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_still_r, out_mg_r, out_rate_r, out_ts_r};
  assign out_tuser  = out_done_r;

endmodule

>>> rtl/iwsd_ctrl.sv
// Controller: one-hot sequencer that issues one datapath command per cycle.
// Depends on iwsd_pkg for command and status types.
module iwsd_ctrl import iwsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_opcode,
  input  sts_t sts,
  output logic in_tready,
  output cmd_t cmd
);

  typedef enum logic [36:0] {
    ST_IDLE       = 37'b1 << 0,
    ST_TS_MUL     = 37'b1 << 1,
    ST_TS_SUB     = 37'b1 << 2,
    ST_SQ         = 37'b1 << 3,
    ST_SQ_ADD     = 37'b1 << 4,
    ST_RT_INIT    = 37'b1 << 5,
    ST_RT_STEP    = 37'b1 << 6,
    ST_ACC_A      = 37'b1 << 7,
    ST_ACC_A2     = 37'b1 << 8,
    ST_ACC_G      = 37'b1 << 9,
    ST_CHK        = 37'b1 << 10,
    ST_NRATE      = 37'b1 << 11,
    ST_RATE_SAT   = 37'b1 << 12,
    ST_RATE_START = 37'b1 << 13,
    ST_RATE_WAIT  = 37'b1 << 14,
    ST_RATE_RES   = 37'b1 << 15,
    ST_MEAS_START = 37'b1 << 16,
    ST_MEAS_WAIT  = 37'b1 << 17,
    ST_P9         = 37'b1 << 18,
    ST_NP_START   = 37'b1 << 19,
    ST_NP_WAIT    = 37'b1 << 20,
    ST_PER        = 37'b1 << 21,
    ST_MG1        = 37'b1 << 22,
    ST_MG_SAT     = 37'b1 << 23,
    ST_MG2        = 37'b1 << 24,
    ST_MG_START   = 37'b1 << 25,
    ST_MG_WAIT    = 37'b1 << 26,
    ST_MG_RES     = 37'b1 << 27,
    ST_L1         = 37'b1 << 28,
    ST_L2         = 37'b1 << 29,
    ST_L3         = 37'b1 << 30,
    ST_L4         = 37'b1 << 31,
    ST_R1         = 37'b1 << 32,
    ST_R2         = 37'b1 << 33,
    ST_R3         = 37'b1 << 34,
    ST_R4         = 37'b1 << 35,
    ST_OUT        = 37'b1 << 36
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] k_r, k_nxt;
  logic       sensor_r, sensor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      sensor_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      sensor_r <= sensor_nxt;
    end
  end

  assign in_tready = state_r == ST_IDLE;
  assign cmd.idx   = 3'(sensor_r ? (k_r + 4'd3) : k_r);

  // Advance the sequence and issue the command for this cycle
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    sensor_nxt = sensor_r;
    cmd.uop    = UOP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.uop   = UOP_LOAD;
          state_nxt = in_opcode ? ST_CHK : ST_TS_MUL;
        end
      end
      ST_TS_MUL: begin
        cmd.uop   = UOP_TS_MUL;
        state_nxt = ST_TS_SUB;
      end
      ST_TS_SUB: begin
        cmd.uop    = UOP_TS_SUB;
        k_nxt      = '0;
        sensor_nxt = 1'b0;
        state_nxt  = sts.full ? ST_OUT : ST_SQ;
      end
      ST_SQ: begin
        cmd.uop = UOP_SQ;
        k_nxt   = k_r + 1'b1;
        if (k_r == 4'd2) begin
          k_nxt     = '0;
          state_nxt = ST_SQ_ADD;
        end
      end
      ST_SQ_ADD: begin
        cmd.uop   = UOP_SQ_ADD;
        state_nxt = ST_RT_INIT;
      end
      ST_RT_INIT: begin
        cmd.uop   = UOP_RT_INIT;
        state_nxt = ST_RT_STEP;
      end
      ST_RT_STEP: begin
        cmd.uop = UOP_RT_STEP;
        k_nxt   = k_r + 1'b1;
        if (k_r == 4'd15) begin
          k_nxt     = '0;
          state_nxt = sensor_r ? ST_ACC_G : ST_ACC_A;
        end
      end
      ST_ACC_A: begin
        cmd.uop   = UOP_ACC_A;
        state_nxt = ST_ACC_A2;
      end
      ST_ACC_A2: begin
        cmd.uop    = UOP_ACC_A2;
        sensor_nxt = 1'b1;
        state_nxt  = ST_SQ;
      end
      ST_ACC_G: begin
        cmd.uop   = UOP_ACC_G;
        state_nxt = ST_OUT;
      end
      ST_CHK: begin
        cmd.uop   = UOP_CHK;
        state_nxt = sts.close ? ST_NRATE : ST_OUT;
      end
      ST_NRATE: begin
        cmd.uop   = UOP_NRATE;
        state_nxt = sts.el_zero ? ST_RATE_SAT : ST_RATE_START;
      end
      ST_RATE_SAT: begin
        cmd.uop   = UOP_RATE_SAT;
        state_nxt = ST_MG1;
      end
      ST_RATE_START: begin
        cmd.uop   = UOP_RATE_START;
        state_nxt = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: if (!sts.div_busy) state_nxt = ST_RATE_RES;
      ST_RATE_RES: begin
        cmd.uop   = UOP_RATE_RES;
        state_nxt = sts.upd ? ST_MEAS_START : ST_MG1;
      end
      ST_MEAS_START: begin
        cmd.uop   = UOP_MEAS_START;
        state_nxt = ST_MEAS_WAIT;
      end
      ST_MEAS_WAIT: if (!sts.div_busy) state_nxt = ST_P9;
      ST_P9: begin
        cmd.uop   = UOP_P9;
        state_nxt = ST_NP_START;
      end
      ST_NP_START: begin
        cmd.uop   = UOP_NP_START;
        state_nxt = ST_NP_WAIT;
      end
      ST_NP_WAIT: if (!sts.div_busy) state_nxt = ST_PER;
      ST_PER: begin
        cmd.uop   = UOP_PER;
        state_nxt = ST_MG1;
      end
      ST_MG1: begin
        cmd.uop   = UOP_MG1;
        state_nxt = sts.cpg_zero ? ST_MG_SAT : ST_MG2;
      end
      ST_MG_SAT: begin
        cmd.uop   = UOP_MG_SAT;
        state_nxt = ST_L1;
      end
      ST_MG2: begin
        cmd.uop   = UOP_MG2;
        state_nxt = ST_MG_START;
      end
      ST_MG_START: begin
        cmd.uop   = UOP_MG_START;
        state_nxt = ST_MG_WAIT;
      end
      ST_MG_WAIT: if (!sts.div_busy) state_nxt = ST_MG_RES;
      ST_MG_RES: begin
        cmd.uop   = UOP_MG_RES;
        state_nxt = ST_L1;
      end
      ST_L1: begin cmd.uop = UOP_L1; state_nxt = ST_L2; end
      ST_L2: begin cmd.uop = UOP_L2; state_nxt = ST_L3; end
      ST_L3: begin cmd.uop = UOP_L3; state_nxt = ST_L4; end
      ST_L4: begin cmd.uop = UOP_L4; state_nxt = ST_R1; end
      ST_R1: begin cmd.uop = UOP_R1; state_nxt = ST_R2; end
      ST_R2: begin cmd.uop = UOP_R2; state_nxt = ST_R3; end
      ST_R3: begin cmd.uop = UOP_R3; state_nxt = ST_R4; end
      ST_R4: begin cmd.uop = UOP_R4; state_nxt = ST_OUT; end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.uop   = UOP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/imu_window_stillness_detector_core.sv
// Channel | Dir | Fields (low bit first)
// in_     | in  | tdata: read_time_us, position_from_end, accel_x/y/z, gyro_x/y/z; tuser: opcode
// out_    | out | tdata: timestamp_us, rate_x10, acc_mean_mg, still; tuser: window_done
// cfg_    | in  | register i at byte address 4*i
//
// One word is processed at a time. A sample word runs two 16-step square roots
// unless the window is full. A check word that leaves the window open goes from
// the check state to the output; one that closes it runs the 56-step serial
// divider up to four times. The result sits in an output register, so a
// stalled output holds only the next result. Reset is synchronous, active low.
// Top level: APB register file, controller and datapath. Depends on iwsd_pkg,
// iwsd_ctrl, iwsd_dp and the assertion macro header.
module imu_window_stillness_detector_core import iwsd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,   // read_time_us, position_from_end, accel_x..z, gyro_x..z
  input  logic         in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // timestamp_us, rate_x10, acc_mean_mg, still, zero pad
  output logic         out_tuser,  // window_done
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t     cfg_r;
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  cmd_t     cmd;
  sts_t     sts;
  logic     per_load;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign per_load   = cfg_wr && (cfg_idx == REG_NOMINAL);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_us          <= WINDOW_US_RST;
      cfg_r.still_acc_std      <= ACC_STD_RST;
      cfg_r.still_gyro_mean    <= GYRO_MEAN_RST;
      cfg_r.accel_counts_per_g <= CPG_RST;
      cfg_r.min_rate_x10       <= MIN_RATE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_US: cfg_r.window_us          <= cfg_pwdata[23:0];
        REG_ACC_STD:   cfg_r.still_acc_std      <= cfg_pwdata[15:0];
        REG_GYRO_MEAN: cfg_r.still_gyro_mean    <= cfg_pwdata[15:0];
        REG_CPG:       cfg_r.accel_counts_per_g <= cfg_pwdata[15:0];
        REG_MIN_RATE:  cfg_r.min_rate_x10       <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Nominal period is kept for readback; the live period sits in the datapath
  logic [PER_W-1:0] nominal_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= PERIOD_RST;
    end else if (per_load) begin
      nominal_r <= cfg_pwdata[PER_W-1:0];
    end
  end

  // Register reads
  always_comb begin
    case (cfg_idx)
      REG_WINDOW_US: cfg_prdata = 32'(cfg_r.window_us);
      REG_ACC_STD:   cfg_prdata = 32'(cfg_r.still_acc_std);
      REG_GYRO_MEAN: cfg_prdata = 32'(cfg_r.still_gyro_mean);
      REG_CPG:       cfg_prdata = 32'(cfg_r.accel_counts_per_g);
      REG_NOMINAL:   cfg_prdata = 32'(nominal_r);
      REG_MIN_RATE:  cfg_prdata = 32'(cfg_r.min_rate_x10);
      default:       cfg_prdata = '0;
    endcase
  end

  iwsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_opcode(in_tuser),
    .sts      (sts),
    .in_tready(in_tready),
    .cmd      (cmd)
  );

  iwsd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .per_load    (per_load),
    .per_load_val(cfg_pwdata[PER_W-1:0]),
    .in_tdata    (in_tdata),
    .out_tready  (out_tready),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

`include "imu_window_stillness_detector_core_assert.svh"

  `IWSD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "word taken while busy")
  `IWSD_ASSERT_SAME(a_check_no_ts, out_tvalid && out_tuser, out_tdata[47:0] == 48'd0, "window report with timestamp")
  `IWSD_ASSERT_SAME(a_sample_no_stats, out_tvalid && !out_tuser, out_tdata[84:48] == 37'd0, "sample result with statistics")

endmodule

>>> verif/imu_window_stillness_detector_core_tb.sv
// Self-checking testbench for the IMU window stillness detector core.
// Sends sample and window-check words, predicts or takes each expected result and compares it.
// Depends on iwsd_pkg and the imu_window_stillness_detector_core RTL.
module imu_window_stillness_detector_core_tb;
  import iwsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned T_MASK = 64'hFFFF_FFFF_FFFF;
  localparam bit OP_SAMPLE = 1'b0;
  localparam bit OP_CHECK  = 1'b1;

  typedef struct {
    bit               op;
    logic [47:0]      t;
    logic [6:0]       pos;
    logic [15:0]      acc [3];
    logic [15:0]      gyr [3];
  } imu_word_t;

  typedef struct {
    logic [47:0] ts;
    logic        done;
    logic [19:0] rate;
    logic [15:0] mg;
    logic        still;
  } detect_res_t;

  // Directed row: a word plus an optional typed expectation
  typedef struct {
    imu_word_t   w;
    bit          fixed;
    detect_res_t res;
  } vec_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;    // read_time_us, position_from_end, accel_x..z, gyro_x..z
  logic         in_tuser = 0;     // opcode
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [87:0]  out_tdata;        // timestamp_us, rate_x10, acc_mean_mg, still
  logic         out_tuser;        // window_done
  logic         cfg_psel = 0;
  logic         cfg_penable = 0;
  logic         cfg_pwrite = 0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  imu_window_stillness_detector_core u_top (.*);

  always #5 clk = ~clk;

  // Mirror of the registers and the window state
  longint unsigned win_us, acc_std, gyro_mean, cnt_per_g, nom_period, min_rate;
  longint unsigned n_samples, acc_sum, acc_sq_sum, gyro_sum, win_start, period;

  detect_res_t     pending [$];
  int              errors = 0;
  int              in_idle = 0;
  int              out_stall = 0;
  longint unsigned now_us = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 40;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned vec_norm(input logic [15:0] v [3]);
    longint unsigned s = 0;
    longint unsigned m;
    for (int i = 0; i < 3; i++) begin
      m = v[i][15] ? (64'd65536 - v[i]) : v[i];
      s += m * m;
    end
    return int_sqrt(s);
  endfunction

  // Advance the window state by one word and return its result
  function automatic detect_res_t detect_step(input imu_word_t w);
    detect_res_t     r = '{default: '0};
    longint unsigned el, q, rm, lhs, sq, rhs, an, np;
    if (w.op == OP_SAMPLE) begin
      r.ts = (w.t - ((longint'(w.pos) * period) >> 4)) & T_MASK;
      if (n_samples < MAX_WINDOW_SAMPLES) begin
        an = vec_norm(w.acc);
        acc_sum += an;
        acc_sq_sum += an * an;
        gyro_sum += vec_norm(w.gyr);
        n_samples++;
      end
      return r;
    end
    if (w.t < win_start || (w.t - win_start) < win_us || n_samples == 0) return r;
    el = w.t - win_start;
    if (el == 0) begin
      r.rate = '1;
    end else begin
      q = n_samples * 10000000 / el;
      rm = n_samples * 10000000 % el;
      r.rate = (q > 20'hFFFFF) ? 20'hFFFFF : q[19:0];
      if (q > min_rate || (q == min_rate && rm > 0)) begin
        np = (9 * period + (el * 16) / n_samples + 5) / 10;
        period = (np > 24'hFFFFFF) ? 24'hFFFFFF : np;
      end
    end
    if (cnt_per_g == 0) begin
      r.mg = '1;
    end else begin
      q = acc_sum * 1000 / (n_samples * cnt_per_g);
      r.mg = (q > 16'hFFFF) ? 16'hFFFF : q[15:0];
    end
    lhs = n_samples * acc_sq_sum;
    sq = acc_sum * acc_sum;
    lhs = (lhs > sq) ? lhs - sq : 0;
    rhs = acc_std * acc_std * n_samples * n_samples;
    r.still = (lhs < rhs) && (gyro_sum < gyro_mean * n_samples);
    r.done = 1;
    n_samples = 0;
    acc_sum = 0;
    acc_sq_sum = 0;
    gyro_sum = 0;
    win_start = w.t;
    return r;
  endfunction

  task automatic report(input string what, input longint unsigned got, input longint unsigned want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    detect_res_t e;
    out_tready <= ($urandom_range(0, 99) >= out_stall);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        report("unexpected result", out_tdata, 0);
      end else begin
        e = pending.pop_front();
        if (out_tdata[47:0] !== e.ts) report("timestamp_us", out_tdata[47:0], e.ts);
        if (out_tuser !== e.done) report("window_done", out_tuser, e.done);
        if (out_tdata[67:48] !== e.rate) report("rate_x10", out_tdata[67:48], e.rate);
        if (out_tdata[83:68] !== e.mg) report("acc_mean_mg", out_tdata[83:68], e.mg);
        if (out_tdata[84] !== e.still) report("still", out_tdata[84], e.still);
      end
    end
  end

  // Hold the word until accepted, then queue its expected result
  task automatic send_word(input imu_word_t w, input bit fixed = 0,
                           input detect_res_t fr = '{default: '0});
    detect_res_t p;
    while ($urandom_range(0, 99) < in_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= w.op;
    in_tdata <= {1'b0, w.gyr[2], w.gyr[1], w.gyr[0], w.acc[2], w.acc[1], w.acc[0],
                 w.pos, w.t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = detect_step(w);
    pending.push_back(fixed ? fr : p);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rb;
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk); cfg_penable <= 1;
    @(posedge clk); cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk); cfg_penable <= 1;
    @(posedge clk); rb = cfg_prdata; cfg_psel <= 0; cfg_penable <= 0;
    case (idx)
      REG_WINDOW_US: begin win_us = val[23:0]; val = val[23:0]; end
      REG_ACC_STD:   begin acc_std = val[15:0]; val = val[15:0]; end
      REG_GYRO_MEAN: begin gyro_mean = val[15:0]; val = val[15:0]; end
      REG_CPG:       begin cnt_per_g = val[15:0]; val = val[15:0]; end
      REG_NOMINAL:   begin nom_period = val[23:0]; period = val[23:0]; val = val[23:0]; end
      default:       begin min_rate = val[19:0]; val = val[19:0]; end
    endcase
    if (rb !== val) report("register readback", rb, val);
  endtask

  task automatic set_regs(input int w, input int s, input int g, input int c, input int n,
                          input int m);
    reg_write(REG_WINDOW_US, w);
    reg_write(REG_ACC_STD, s);
    reg_write(REG_GYRO_MEAN, g);
    reg_write(REG_CPG, c);
    reg_write(REG_NOMINAL, n);
    reg_write(REG_MIN_RATE, m);
  endtask

  function automatic imu_word_t mk(input bit op, input longint unsigned t, input int pos,
                                   input int ax, input int ay, input int az,
                                   input int gx, input int gy, input int gz);
    imu_word_t w;
    w.op = op; w.t = t[47:0]; w.pos = pos[6:0];
    w.acc[0] = ax[15:0]; w.acc[1] = ay[15:0]; w.acc[2] = az[15:0];
    w.gyr[0] = gx[15:0]; w.gyr[1] = gy[15:0]; w.gyr[2] = gz[15:0];
    return w;
  endfunction

  // Random sample: mostly near rest on a flat surface, some full-range noise
  function automatic imu_word_t rand_sample();
    imu_word_t w;
    int        pos;
    pos = ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(0, 20);
    if ($urandom_range(0, 3) != 0)
      w = mk(OP_SAMPLE, now_us, pos, $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
             8192 + $urandom_range(0, 40) - 20, $urandom_range(0, 60) - 30,
             $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30);
    else
      w = mk(OP_SAMPLE, now_us, pos, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
    return w;
  endfunction

  task automatic random_run(input int items);
    imu_word_t w;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 3) != 0) now_us += $urandom_range(0, 4000);
      if ($urandom_range(0, 11) == 0) begin
        w = mk(OP_CHECK, now_us, 0, 0, 0, 0, 0, 0, 0);
        // late or stale read times now and then
        if ($urandom_range(0, 7) == 0) w.t = (now_us - $urandom_range(0, 100000)) & T_MASK;
        w.pos = $urandom;
        w.acc[0] = $urandom;
        send_word(w);
      end else begin
        send_word(rand_sample());
      end
    end
  endtask

  vec_t vecs [] = '{
    '{mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}},
    '{mk(OP_SAMPLE, 1000, 0, 32767, -32768, 32767, -32768, 32767, -32768), 1,
      '{48'd1000, 0, 0, 0, 0}},
    '{mk(OP_SAMPLE, 5, 127, 0, 0, 0, 0, 0, 0), 0, '{default: '0}},
    '{mk(OP_SAMPLE, T_MASK, 0, -32768, -32768, -32768, -32768, -32768, -32768), 1,
      '{48'hFFFF_FFFF_FFFF, 0, 0, 0, 0}},
    '{mk(OP_SAMPLE, 200000, 100, 1, -1, 8192, 3, -3, 5), 0, '{default: '0}},
    '{mk(OP_CHECK, 500000, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}},
    '{mk(OP_CHECK, 1000000, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0}},
    '{mk(OP_SAMPLE, 1100000, 3, 0, 0, 8192, 1, 1, 1), 0, '{default: '0}},
    '{mk(OP_SAMPLE, 1100000, 2, 2, 0, 8190, 0, 2, 1), 0, '{default: '0}},
    '{mk(OP_SAMPLE, 1100000, 1, 0, 3, 8194, 1, 0, 0), 0, '{default: '0}},
    '{mk(OP_SAMPLE, 1100000, 0, 1, 1, 8193, 0, 0, 2), 0, '{default: '0}},
    '{mk(OP_CHECK, 10, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}},
    '{mk(OP_CHECK, 2000000, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0}},
    '{mk(OP_SAMPLE, 2000100, 127, 32767, 32767, 32767, 32767, 32767, 32767), 0,
      '{default: '0}},
    '{mk(OP_CHECK, 2999999, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}},
    '{mk(OP_CHECK, 3000000, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0}}
  };

  initial begin
    win_us = 1000000; acc_std = 17; gyro_mean = 66; cnt_per_g = 8192;
    nom_period = 71111; min_rate = 500;
    n_samples = 0; acc_sum = 0; acc_sq_sum = 0; gyro_sum = 0; win_start = 0;
    period = nom_period;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed words at reset settings
    foreach (vecs[i]) send_word(vecs[i].w, vecs[i].fixed, vecs[i].res);
    now_us = 3000000;
    drain();

    // Extreme settings: tiny window, widest thresholds, one count per g
    set_regs(1000, 65535, 65535, 1, 1, 0);
    random_run(120);
    drain();

    // Zero window, zero thresholds and zero counts per g; sender idles
    set_regs(0, 0, 0, 0, 24'hFFFFFF, 20'hFFFFF);
    in_idle = 73;
    random_run(120);
    drain();

    // Receiver stalls
    set_regs($urandom_range(1, 20000), $urandom_range(0, 64), $urandom_range(0, 200), 8192,
             $urandom_range(1, 200000), $urandom_range(0, 2000));
    in_idle = 0; out_stall = 73;
    random_run(60);
    drain();
    random_run(60);
    drain();

    // Both sides idle
    set_regs(24'hFFFFFF, $urandom_range(0, 64), $urandom_range(0, 200), $urandom_range(1, 65535),
             $urandom_range(1, 200000), $urandom_range(0, 2000));
    in_idle = 28; out_stall = 28;
    random_run(40);
    drain();
    set_regs($urandom_range(1, 20000), $urandom_range(0, 64), $urandom_range(0, 200), 8192,
             $urandom_range(1, 200000), $urandom_range(0, 2000));
    random_run(120);
    drain();

    // Overfill one window past its sample limit
    set_regs(1, 20, 100, 8192, 71111, 500);
    in_idle = 0; out_stall = 0;
    for (int i = 0; i < MAX_WINDOW_SAMPLES + 8; i++) send_word(rand_sample());
    now_us += 5000;
    send_word(mk(OP_CHECK, now_us, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Back-to-back words at moderate settings
    set_regs($urandom_range(1, 20000), $urandom_range(0, 64), $urandom_range(0, 200), 8192,
             $urandom_range(1, 200000), $urandom_range(0, 2000));
    random_run(150);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
